/* rtl/urb_pkg.sv */
// Package for the UART ring buffers with XON/XOFF flow control.
// Holds the request codes, register indexes, control bytes and default sizes.
// No dependencies.
`timescale 1ns / 1ps

package urb_pkg;

    localparam int RX_DEPTH_DEF = 32;
    localparam int TX_DEPTH_DEF = 16;

    localparam logic [7:0]  XON_BYTE  = 8'h11;
    localparam logic [7:0]  XOFF_BYTE = 8'h13;
    localparam logic [7:0]  CTRL_NONE = 8'h00;
    localparam logic [15:0] FILL_MAX  = 16'hFFFF;

    localparam logic [4:0] FLOW_MARGIN_RESET = 5'd5;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register index, taken from paddr[2].
    typedef enum logic {
        REG_FLOW_ENABLE = 1'b0,
        REG_FLOW_MARGIN = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        REQ_LINE_RX  = 2'd0,
        REQ_HOST_RD  = 2'd1,
        REQ_HOST_WR  = 2'd2,
        REQ_TX_READY = 2'd3
    } req_type_t;

endpackage

/* rtl/urb_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing; used for both ring stores.
`timescale 1ns / 1ps

module urb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/uart_ring_buffers_xon_xoff.sv */
// Top level: receive and transmit rings of one UART channel with XON/XOFF control.
// Depends on urb_pkg and urb_ram.
//
//  channel   direction  handshake           payload
//  s_        in         s_valid / s_ready   s_req_type, s_data_in
//  m_        out        m_valid / m_ready   read/write status, line byte, ring flags
//  apb       in         psel/penable/pready flow_enable (0x0), flow_margin (0x4)
//
// Each transaction is handled at its accepting edge: pointers, counters and flow state
// update at that edge, and the result register loads at that same edge.
// Ring bytes come from the registered RAM read port issued at that edge.
// One transaction per cycle while m_ready is high; a held result blocks s_ready.
// aresetn is synchronous and active low; the ring stores are not cleared.
`timescale 1ns / 1ps

module uart_ring_buffers_xon_xoff
    import urb_pkg::*;
#(
    parameter int RX_DEPTH = RX_DEPTH_DEF,
    parameter int TX_DEPTH = TX_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic [7:0]         s_data_in,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_read_data,
    output logic               m_read_ok,
    output logic               m_write_ok,
    output logic [7:0]         m_line_byte,
    output logic               m_line_valid,
    output logic               m_tx_kick,
    output logic               m_rx_empty,
    output logic               m_rx_full,
    output logic               m_tx_empty,
    output logic               m_tx_full,
    output logic               m_flow_on,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
    localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);
    localparam logic [16:0] RX_DEPTH_W = 17'(RX_DEPTH);

    // Configuration registers.
    logic       flow_enable_reg;
    logic [4:0] flow_margin_reg;
    logic       cfg_wr;
    reg_idx_t   cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flow_enable_reg <= 1'b0;
            flow_margin_reg <= FLOW_MARGIN_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_FLOW_ENABLE: flow_enable_reg <= pwdata[0];
                REG_FLOW_MARGIN: flow_margin_reg <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_FLOW_ENABLE: prdata = {{(PDATA_W-1){1'b0}}, flow_enable_reg};
            REG_FLOW_MARGIN: prdata = {{(PDATA_W-5){1'b0}}, flow_margin_reg};
            default:         prdata = '0;
        endcase
    end

    // Channel state.
    logic [RX_AW-1:0] rx_head_reg, rx_head_next, rx_tail_reg, rx_tail_next;
    logic [TX_AW-1:0] tx_head_reg, tx_head_next, tx_tail_reg, tx_tail_next;
    logic             tx_idle_reg, tx_idle_next;
    logic [7:0]       pending_reg, pending_next;
    logic             allowed_reg, allowed_next;
    logic [15:0]      fill_reg, fill_next;

    // Result register.
    logic       m_valid_reg;
    logic       rd_sel_reg, rd_sel_next;
    logic       read_ok_reg, read_ok_next;
    logic       write_ok_reg, write_ok_next;
    logic       tx_sel_reg, tx_sel_next;
    logic [7:0] ctrl_byte_reg, ctrl_byte_next;
    logic       line_valid_reg, line_valid_next;
    logic       kick_reg, kick_next;
    logic       rx_empty_reg, rx_full_reg, tx_empty_reg, tx_full_reg;

    // RAM ports.
    logic       rx_we, rx_re, tx_we, tx_re;
    logic [7:0] rx_q, tx_q;

    logic             s_acc;
    req_type_t        req;
    logic [RX_AW-1:0] rx_head_inc, rx_tail_inc, rx_head_nn;
    logic [TX_AW-1:0] tx_head_inc, tx_tail_inc, tx_head_nn;
    logic             rx_full_cur, tx_full_cur;
    logic [15:0]      fill_inc, fill_dec;
    logic             need_xon;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_acc   = s_valid && s_ready;
    assign req     = req_type_t'(s_req_type);

    assign rx_head_inc = (rx_head_reg == RX_LAST) ? '0 : rx_head_reg + 1'b1;
    assign rx_tail_inc = (rx_tail_reg == RX_LAST) ? '0 : rx_tail_reg + 1'b1;
    assign tx_head_inc = (tx_head_reg == TX_LAST) ? '0 : tx_head_reg + 1'b1;
    assign tx_tail_inc = (tx_tail_reg == TX_LAST) ? '0 : tx_tail_reg + 1'b1;
    assign rx_full_cur = (rx_head_inc == rx_tail_reg);
    assign tx_full_cur = (tx_head_inc == tx_tail_reg);
    assign fill_inc    = (fill_reg == FILL_MAX) ? fill_reg : fill_reg + 16'd1;
    assign fill_dec    = (fill_reg == 16'd0) ? 16'd0 : fill_reg - 16'd1;
    assign need_xon    = flow_enable_reg && !allowed_reg && (fill_dec <= 16'(flow_margin_reg));

    always_comb begin
        rx_head_next    = rx_head_reg;
        rx_tail_next    = rx_tail_reg;
        tx_head_next    = tx_head_reg;
        tx_tail_next    = tx_tail_reg;
        tx_idle_next    = tx_idle_reg;
        pending_next    = pending_reg;
        allowed_next    = allowed_reg;
        fill_next       = fill_reg;
        rd_sel_next     = 1'b0;
        read_ok_next    = 1'b0;
        write_ok_next   = 1'b0;
        tx_sel_next     = 1'b0;
        ctrl_byte_next  = CTRL_NONE;
        line_valid_next = 1'b0;
        kick_next       = 1'b0;
        rx_we           = 1'b0;
        rx_re           = 1'b0;
        tx_we           = 1'b0;
        tx_re           = 1'b0;
        if (s_acc) begin
            case (req)
                REQ_LINE_RX: begin
                    // A full ring takes the byte at the head slot without advancing.
                    rx_we     = 1'b1;
                    fill_next = fill_inc;
                    if (!rx_full_cur) begin
                        rx_head_next = rx_head_inc;
                    end
                    if (flow_enable_reg && allowed_reg &&
                        ({1'b0, fill_inc} + 17'(flow_margin_reg) >= RX_DEPTH_W)) begin
                        pending_next = XOFF_BYTE;
                        allowed_next = 1'b0;
                        kick_next    = tx_idle_reg;
                        tx_idle_next = 1'b0;
                    end
                end
                REQ_HOST_RD: begin
                    read_ok_next = 1'b1;
                    if (rx_tail_reg != rx_head_reg) begin
                        // An XON cannot be queued behind a control byte still unsent.
                        if (need_xon && pending_reg != CTRL_NONE) begin
                            read_ok_next = 1'b0;
                        end else begin
                            fill_next    = fill_dec;
                            rx_re        = 1'b1;
                            rd_sel_next  = 1'b1;
                            rx_tail_next = rx_tail_inc;
                            if (need_xon) begin
                                pending_next = XON_BYTE;
                                allowed_next = 1'b1;
                                kick_next    = tx_idle_reg;
                                tx_idle_next = 1'b0;
                            end
                        end
                    end
                end
                REQ_HOST_WR: begin
                    if (!tx_full_cur) begin
                        tx_we         = 1'b1;
                        tx_head_next  = tx_head_inc;
                        write_ok_next = 1'b1;
                        kick_next     = tx_idle_reg;
                        tx_idle_next  = 1'b0;
                    end
                end
                REQ_TX_READY: begin
                    if (pending_reg != CTRL_NONE) begin
                        ctrl_byte_next  = pending_reg;
                        line_valid_next = 1'b1;
                        pending_next    = CTRL_NONE;
                    end else if (tx_tail_reg != tx_head_reg) begin
                        tx_re           = 1'b1;
                        tx_sel_next     = 1'b1;
                        line_valid_next = 1'b1;
                        tx_tail_next    = tx_tail_inc;
                    end else begin
                        tx_idle_next = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign rx_head_nn = (rx_head_next == RX_LAST) ? '0 : rx_head_next + 1'b1;
    assign tx_head_nn = (tx_head_next == TX_LAST) ? '0 : tx_head_next + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_head_reg  <= '0;
            rx_tail_reg  <= '0;
            tx_head_reg  <= '0;
            tx_tail_reg  <= '0;
            tx_idle_reg  <= 1'b1;
            pending_reg  <= CTRL_NONE;
            allowed_reg  <= 1'b1;
            fill_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            rx_head_reg  <= rx_head_next;
            rx_tail_reg  <= rx_tail_next;
            tx_head_reg  <= tx_head_next;
            tx_tail_reg  <= tx_tail_next;
            tx_idle_reg  <= tx_idle_next;
            pending_reg  <= pending_next;
            allowed_reg  <= allowed_next;
            fill_reg     <= fill_next;
            if (s_acc) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            rd_sel_reg     <= rd_sel_next;
            read_ok_reg    <= read_ok_next;
            write_ok_reg   <= write_ok_next;
            tx_sel_reg     <= tx_sel_next;
            ctrl_byte_reg  <= ctrl_byte_next;
            line_valid_reg <= line_valid_next;
            kick_reg       <= kick_next;
            rx_empty_reg   <= (rx_head_next == rx_tail_next);
            rx_full_reg    <= (rx_head_nn == rx_tail_next);
            tx_empty_reg   <= (tx_head_next == tx_tail_next);
            tx_full_reg    <= (tx_head_nn == tx_tail_next);
        end
    end

    urb_ram #(
        .WIDTH (8),
        .DEPTH (RX_DEPTH)
    ) u_rx_ram (
        .aclk  (aclk),
        .we    (rx_we),
        .waddr (rx_head_reg),
        .wdata (s_data_in),
        .re    (rx_re),
        .raddr (rx_tail_reg),
        .rdata (rx_q)
    );

    urb_ram #(
        .WIDTH (8),
        .DEPTH (TX_DEPTH)
    ) u_tx_ram (
        .aclk  (aclk),
        .we    (tx_we),
        .waddr (tx_head_reg),
        .wdata (s_data_in),
        .re    (tx_re),
        .raddr (tx_tail_reg),
        .rdata (tx_q)
    );

    // The RAM read data only changes when a transaction is accepted, so it holds while stalled.
    assign m_valid      = m_valid_reg;
    assign m_read_data  = rd_sel_reg ? rx_q : 8'd0;
    assign m_read_ok    = read_ok_reg;
    assign m_write_ok   = write_ok_reg;
    assign m_line_byte  = tx_sel_reg ? tx_q : ctrl_byte_reg;
    assign m_line_valid = line_valid_reg;
    assign m_tx_kick    = kick_reg;
    assign m_rx_empty   = rx_empty_reg;
    assign m_rx_full    = rx_full_reg;
    assign m_tx_empty   = tx_empty_reg;
    assign m_tx_full    = tx_full_reg;
    assign m_flow_on    = allowed_reg;

    a_kick_leaves_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && kick_next) |=> !tx_idle_reg)
        else $error("transmitter kick did not leave the transmitter busy");

    a_pending_code: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg == CTRL_NONE || pending_reg == XON_BYTE || pending_reg == XOFF_BYTE)
        else $error("pending control byte holds an unknown code");

    a_xoff_needs_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(allowed_reg) |-> ($past(flow_enable_reg) && pending_reg == XOFF_BYTE))
        else $error("remote stopped without flow control or without XOFF queued");

    a_ring_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(rx_empty_reg && rx_full_reg) && !(tx_empty_reg && tx_full_reg))
        else $error("ring reported empty and full at once");

    a_one_source: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(line_valid_reg && (read_ok_reg || write_ok_reg)))
        else $error("result carries a line byte together with a host status");

endmodule

/* verif/uart_ring_buffers_xon_xoff_test.sv */
// Self-checking testbench for uart_ring_buffers_xon_xoff: ring buffers and XON/XOFF control.
// A directed table runs first, then random traffic, checked against pinned table values or an in-bench predictor.
// Depends on urb_pkg and the RTL of uart_ring_buffers_xon_xoff.
`timescale 1ns / 1ps

module uart_ring_buffers_xon_xoff_test;
    import urb_pkg::*;

    typedef struct packed {
        logic [7:0] read_data;
        logic       read_ok;
        logic       write_ok;
        logic [7:0] line_byte;
        logic       line_valid;
        logic       tx_kick;
        logic       rx_empty;
        logic       rx_full;
        logic       tx_empty;
        logic       tx_full;
        logic       flow_on;
    } uart_status_t;

    typedef struct {
        req_type_t    req;
        logic [7:0]   data;
        bit           pinned;
        uart_status_t want;
    } chan_step_t;

    localparam int WARMUP_ROWS = 23;
    localparam int PHASES = 9;
    localparam int OVERFILL_BYTES = 40;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_req_type = '0;
    logic [7:0]         s_data_in = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [7:0]         m_read_data;
    logic               m_read_ok;
    logic               m_write_ok;
    logic [7:0]         m_line_byte;
    logic               m_line_valid;
    logic               m_tx_kick;
    logic               m_rx_empty;
    logic               m_rx_full;
    logic               m_tx_empty;
    logic               m_tx_full;
    logic               m_flow_on;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    uart_ring_buffers_xon_xoff dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_data_in    (s_data_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_data  (m_read_data),
        .m_read_ok    (m_read_ok),
        .m_write_ok   (m_write_ok),
        .m_line_byte  (m_line_byte),
        .m_line_valid (m_line_valid),
        .m_tx_kick    (m_tx_kick),
        .m_rx_empty   (m_rx_empty),
        .m_rx_full    (m_rx_full),
        .m_tx_empty   (m_tx_empty),
        .m_tx_full    (m_tx_full),
        .m_flow_on    (m_flow_on),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #4 aclk = ~aclk;

    // Predictor state: a private copy of both rings, the flow state and the registers.
    logic [7:0]   rx_ring [RX_DEPTH_DEF];
    logic [7:0]   tx_ring [TX_DEPTH_DEF];
    int           rx_wr, rx_rd, tx_wr, tx_rd;
    int           fill_level;
    bit           tx_idle, remote_ok;
    logic [7:0]   ctrl_pending;
    bit           flow_en;
    logic [4:0]   margin;

    uart_status_t status_due_q [$];
    uart_status_t pin_want = '0;
    bit           pin_valid = 1'b0;
    uart_status_t got_status;
    uart_status_t model_status;

    int  mismatch_count = 0;
    int  items_taken = 0;
    int  results_checked = 0;
    int  burst_left = 0;
    bit  no_gaps = 1'b0;
    bit  rdy_hold = 1'b0;
    int  rdy_mode = 0;
    int  rdy_mode_left = 0;
    logic [31:0] rdy_pattern = 32'h1;

    chan_step_t  warmup_tbl [WARMUP_ROWS];
    bit          phase_en [PHASES] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
    logic [4:0]  phase_margin [PHASES] = '{5'd5, 5'd1, 5'd16, 5'd5, 5'd16, 5'd0, 5'd31,
                                           5'd8, 5'd12};

    function automatic int ring_next(input int p, input int depth);
        return (p + 1 >= depth) ? 0 : p + 1;
    endfunction

    function automatic uart_status_t predict_channel(input req_type_t req,
                                                     input logic [7:0] data);
        uart_status_t r;
        int           cnt;
        bit           need_xon;
        r = '0;
        case (req)
            REQ_LINE_RX: begin
                rx_ring[rx_wr] = data;
                // A full ring takes the byte in place; the write pointer stays.
                if (ring_next(rx_wr, RX_DEPTH_DEF) != rx_rd)
                    rx_wr = ring_next(rx_wr, RX_DEPTH_DEF);
                if (fill_level < FILL_MAX)
                    fill_level++;
                if (flow_en && remote_ok && fill_level + margin >= RX_DEPTH_DEF) begin
                    ctrl_pending = XOFF_BYTE;
                    remote_ok = 1'b0;
                    r.tx_kick = tx_idle;
                    tx_idle = 1'b0;
                end
            end
            REQ_HOST_RD: begin
                r.read_ok = 1'b1;
                if (rx_rd != rx_wr) begin
                    cnt = (fill_level != 0) ? fill_level - 1 : 0;
                    need_xon = flow_en && !remote_ok && cnt <= margin;
                    if (need_xon && ctrl_pending != CTRL_NONE) begin
                        r.read_ok = 1'b0;
                    end else begin
                        fill_level = cnt;
                        if (need_xon) begin
                            ctrl_pending = XON_BYTE;
                            remote_ok = 1'b1;
                            r.tx_kick = tx_idle;
                            tx_idle = 1'b0;
                        end
                        r.read_data = rx_ring[rx_rd];
                        rx_ring[rx_rd] = '0;
                        rx_rd = ring_next(rx_rd, RX_DEPTH_DEF);
                    end
                end
            end
            REQ_HOST_WR: begin
                if (ring_next(tx_wr, TX_DEPTH_DEF) != tx_rd) begin
                    tx_ring[tx_wr] = data;
                    tx_wr = ring_next(tx_wr, TX_DEPTH_DEF);
                    r.write_ok = 1'b1;
                    r.tx_kick = tx_idle;
                    tx_idle = 1'b0;
                end
            end
            default: begin
                if (ctrl_pending != CTRL_NONE) begin
                    r.line_byte = ctrl_pending;
                    r.line_valid = 1'b1;
                    ctrl_pending = CTRL_NONE;
                end else if (tx_rd != tx_wr) begin
                    r.line_byte = tx_ring[tx_rd];
                    r.line_valid = 1'b1;
                    tx_rd = ring_next(tx_rd, TX_DEPTH_DEF);
                end else begin
                    tx_idle = 1'b1;
                end
            end
        endcase
        r.rx_empty = (rx_wr == rx_rd);
        r.rx_full  = (ring_next(rx_wr, RX_DEPTH_DEF) == rx_rd);
        r.tx_empty = (tx_wr == tx_rd);
        r.tx_full  = (ring_next(tx_wr, TX_DEPTH_DEF) == tx_rd);
        r.flow_on  = remote_ok;
        return r;
    endfunction

    function automatic void note_field(input string what, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what,
                     want, got);
    endfunction

    function automatic void compare_status(input uart_status_t want, input uart_status_t got);
        if (got.read_data !== want.read_data)   note_field("read_data", want.read_data, got.read_data);
        if (got.read_ok !== want.read_ok)       note_field("read_ok", want.read_ok, got.read_ok);
        if (got.write_ok !== want.write_ok)     note_field("write_ok", want.write_ok, got.write_ok);
        if (got.line_byte !== want.line_byte)   note_field("line_byte", want.line_byte, got.line_byte);
        if (got.line_valid !== want.line_valid) note_field("line_valid", want.line_valid,
                                                           got.line_valid);
        if (got.tx_kick !== want.tx_kick)       note_field("tx_kick", want.tx_kick, got.tx_kick);
        if (got.rx_empty !== want.rx_empty)     note_field("rx_empty", want.rx_empty, got.rx_empty);
        if (got.rx_full !== want.rx_full)       note_field("rx_full", want.rx_full, got.rx_full);
        if (got.tx_empty !== want.tx_empty)     note_field("tx_empty", want.tx_empty, got.tx_empty);
        if (got.tx_full !== want.tx_full)       note_field("tx_full", want.tx_full, got.tx_full);
        if (got.flow_on !== want.flow_on)       note_field("flow_on", want.flow_on, got.flow_on);
    endfunction

    // Both channels are observed at the rising edge, on values settled since the falling edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                model_status = predict_channel(req_type_t'(s_req_type), s_data_in);
                status_due_q.push_back(pin_valid ? pin_want : model_status);
                items_taken++;
            end
            if (m_valid && m_ready) begin
                got_status = '{m_read_data, m_read_ok, m_write_ok, m_line_byte, m_line_valid,
                               m_tx_kick, m_rx_empty, m_rx_full, m_tx_empty, m_tx_full,
                               m_flow_on};
                results_checked++;
                if (status_due_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("[%0t] result transaction with nothing outstanding",
                                 $realtime);
                end else begin
                    compare_status(status_due_q.pop_front(), got_status);
                end
            end
        end
    end

    // Unless held ready, the result side stalls in modes: always ready, a rotating bit pattern, or random ready 3 in 4.
    always @(negedge aclk) begin
        if (rdy_hold) begin
            m_ready <= 1'b1;
        end else begin
            if (rdy_mode_left == 0) begin
                rdy_mode = $urandom_range(0, 2);
                rdy_pattern = $urandom | 32'h1;
                rdy_mode_left = $urandom_range(16, 96);
            end
            rdy_mode_left--;
            case (rdy_mode)
                0: m_ready <= 1'b1;
                1: begin
                    m_ready <= rdy_pattern[0];
                    rdy_pattern = {rdy_pattern[0], rdy_pattern[31:1]};
                end
                default: m_ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction is taken.
    task automatic send_item(input req_type_t req, input logic [7:0] data,
                             input bit pinned, input uart_status_t want);
        int gap;
        if (burst_left == 0 && !no_gaps) begin
            gap = $urandom_range(0, 10);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_data_in  <= data;
        pin_valid  <= pinned;
        pin_want   <= want;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic wait_drained();
        s_valid   <= 1'b0;
        pin_valid <= 1'b0;
        while (status_due_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic apb_access(input bit wr, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rdata = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_flow(input bit en, input logic [4:0] m);
        logic [PDATA_W-1:0] rd;
        apb_access(1'b1, {REG_FLOW_ENABLE, 2'b00}, PDATA_W'(en), rd);
        apb_access(1'b1, {REG_FLOW_MARGIN, 2'b00}, PDATA_W'(m), rd);
        flow_en = en;
        margin  = m;
        apb_access(1'b0, {REG_FLOW_ENABLE, 2'b00}, '0, rd);
        if (rd !== PDATA_W'(en))
            note_field("flow_enable readback", en, rd);
        apb_access(1'b0, {REG_FLOW_MARGIN, 2'b00}, '0, rd);
        if (rd !== PDATA_W'(m))
            note_field("flow_margin readback", m, rd);
    endtask

    // Runs of one request kind fill and drain the rings; short mixed runs add noise.
    task automatic run_random(input int count);
        int        kind, run, k, j;
        req_type_t req;
        k = 0;
        while (k < count) begin
            kind = $urandom_range(0, 5);
            case (kind)
                0:       run = $urandom_range(1, 40);
                1:       run = $urandom_range(1, 36);
                2:       run = $urandom_range(1, 18);
                3:       run = $urandom_range(1, 20);
                default: run = $urandom_range(1, 8);
            endcase
            for (j = 0; j < run && k < count; j++) begin
                case (kind)
                    0:       req = REQ_LINE_RX;
                    1:       req = REQ_HOST_RD;
                    2:       req = REQ_HOST_WR;
                    3:       req = REQ_TX_READY;
                    default: req = req_type_t'($urandom_range(0, 3));
                endcase
                send_item(req, 8'($urandom_range(0, 255)), 1'b0, '0);
                k++;
            end
        end
    endtask

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int i;
        rx_wr = 0;
        rx_rd = 0;
        tx_wr = 0;
        tx_rd = 0;
        fill_level = 0;
        tx_idle = 1'b1;
        remote_ok = 1'b1;
        ctrl_pending = CTRL_NONE;
        flow_en = 1'b0;
        margin = FLOW_MARGIN_RESET;

        // With a margin of 31 the first received byte raises XOFF, so the refused read,
        // both control bytes and the idle restart all show up within a few transactions.
        warmup_tbl = '{
            '{REQ_HOST_RD,  8'h00, 1'b1, '{8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0,
                                           1'b1, 1'b0, 1'b1, 1'b0, 1'b1}},
            '{REQ_TX_READY, 8'hFF, 1'b1, '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0,
                                           1'b1, 1'b0, 1'b1, 1'b0, 1'b1}},
            '{REQ_HOST_WR,  8'hFF, 1'b1, '{8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b1,
                                           1'b1, 1'b0, 1'b0, 1'b0, 1'b1}},
            '{REQ_HOST_WR,  8'h00, 1'b1, '{8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0,
                                           1'b1, 1'b0, 1'b0, 1'b0, 1'b1}},
            '{REQ_HOST_WR,  8'h5A, 1'b0, '0},
            '{REQ_LINE_RX,  8'hFF, 1'b1, '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0,
                                           1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
            '{REQ_HOST_RD,  8'hA5, 1'b1, '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0,
                                           1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
            '{REQ_TX_READY, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, XOFF_BYTE, 1'b1, 1'b0,
                                           1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
            '{REQ_HOST_RD,  8'h00, 1'b1, '{8'hFF, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0,
                                           1'b1, 1'b0, 1'b0, 1'b0, 1'b1}},
            '{REQ_LINE_RX,  8'h00, 1'b0, '0},
            '{REQ_TX_READY, 8'h3C, 1'b0, '0},
            '{REQ_TX_READY, 8'hC3, 1'b0, '0},
            '{REQ_TX_READY, 8'h00, 1'b0, '0},
            '{REQ_TX_READY, 8'hFF, 1'b0, '0},
            '{REQ_TX_READY, 8'h00, 1'b0, '0},
            '{REQ_HOST_RD,  8'hFF, 1'b0, '0},
            '{REQ_TX_READY, 8'h00, 1'b0, '0},
            '{REQ_TX_READY, 8'h00, 1'b0, '0},
            '{REQ_LINE_RX,  8'h80, 1'b0, '0},
            '{REQ_TX_READY, 8'h01, 1'b0, '0},
            '{REQ_HOST_RD,  8'h00, 1'b0, '0},
            '{REQ_TX_READY, 8'h7F, 1'b0, '0},
            '{REQ_TX_READY, 8'hFE, 1'b0, '0}
        };

        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        set_flow(1'b1, 5'd31);
        for (i = 0; i < WARMUP_ROWS; i++)
            send_item(warmup_tbl[i].req, warmup_tbl[i].data, warmup_tbl[i].pinned,
                      warmup_tbl[i].want);
        wait_drained();

        // Each setting is applied while nothing is in flight, with a full drain mid-phase.
        for (i = 0; i < PHASES; i++) begin
            set_flow(phase_en[i], phase_margin[i]);
            run_random(40);
            wait_drained();
            run_random(40);
            wait_drained();
        end

        // Overfill the receive ring at full rate so bytes land in place, then read a few back.
        set_flow(1'b1, 5'd16);
        rdy_hold = 1'b1;
        no_gaps  = 1'b1;
        for (i = 0; i < OVERFILL_BYTES; i++)
            send_item(REQ_LINE_RX, 8'(i), 1'b0, '0);
        for (i = 0; i < 6; i++)
            send_item(REQ_HOST_RD, 8'h00, 1'b0, '0);
        rdy_hold = 1'b0;
        no_gaps  = 1'b0;
        run_random(40);

        s_valid   <= 1'b0;
        pin_valid <= 1'b0;
        for (i = 0; i < 100000 && status_due_q.size() != 0; i++)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (status_due_q.size() != 0) begin
            $display("%0d expected results never arrived", status_due_q.size());
            mismatch_count += status_due_q.size();
        end

        $display("Covered %0d transactions over %0d flow settings, including a full-rate",
                 items_taken, PHASES + 2);
        $display("overfill of the receive ring; checked %0d results, %0d mismatches.",
                 results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
